@@ design/csz_pkg.sv @@
// Shared constants, status codes and types of the column z-score standardiser.
`default_nettype none
package csz_pkg;
   localparam int MAX_SAMPLES   = 64;
   localparam int FRACTION_BITS = 12;
   localparam int SCALE_SHIFT   = 2 * FRACTION_BITS;
   localparam int ADDR_W        = $clog2(MAX_SAMPLES);
   localparam int CNT_W         = $clog2(MAX_SAMPLES + 1);
   localparam int SAMPLE_W      = 16;
   localparam int SUM_W         = 22;
   localparam int SQ_W          = 37;
   localparam int PROD_W        = 44;
   localparam int Q_W           = 43;
   localparam int NQ_W          = Q_W + CNT_W;
   localparam int NUM_W         = NQ_W + SCALE_SHIFT;
   localparam int ROOT_W        = NUM_W / 2;
   localparam int UNIT_W        = ROOT_W + 4;
   localparam int DIFF_W        = 24;
   localparam int MAG_W         = 23;
   localparam int ZNUM_W        = MAG_W + SCALE_SHIFT;
   localparam int STEP_W        = $clog2(NUM_W + 1);
   localparam int Z_W           = 17;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_SAT  = 2'd1;
   localparam logic [1:0] STATUS_FEW  = 2'd2;
   localparam logic [1:0] STATUS_FLAT = 2'd3;

   typedef struct packed {
      logic                       en;
      logic [ADDR_W-1:0]          addr;
      logic signed [SAMPLE_W-1:0] data;
   } csz_wr_type;
endpackage
`default_nettype wire

@@ design/column_z_score_standardizer_top.sv @@
// Top level: load sequencer, shared divide and square-root steps, result register.
//
//   channel  direction  ports
//   req      in         req_valid, req_ready, req_sample, req_last
//   rsp      out        rsp_valid, rsp_ready, rsp_z_value, rsp_position, rsp_status,
//                       rsp_end_of_run
//
// A sample beat is taken in every cycle in which req_valid and req_ready are both high.
// The beat marked last then starts the products and the spread, a 74-step division by
// n-1 and a 37-step square root, all on the single compare-and-subtract unit, and then
// the results, one at a time: the next is not begun until rsp_ready takes the one shown.
// No new sample is taken until the last result has gone.
// Reset empties the block; the sample memory is not cleared.
`default_nettype none
module column_z_score_standardizer_top import csz_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic signed [SAMPLE_W-1:0] req_sample,
   input  wire logic                       req_last,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic signed [Z_W-1:0]           rsp_z_value,
   output logic [ADDR_W-1:0]               rsp_position,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_end_of_run
);
   typedef enum logic [9:0] {
      ST_LOAD  = 10'b0000000001,
      ST_PROD  = 10'b0000000010,
      ST_DIFF  = 10'b0000000100,
      ST_SCALE = 10'b0000001000,
      ST_DIV   = 10'b0000010000,
      ST_ROOT  = 10'b0000100000,
      ST_FETCH = 10'b0001000000,
      ST_NORM  = 10'b0010000000,
      ST_ZDIV  = 10'b0100000000,
      ST_SEND  = 10'b1000000000
   } state_type;

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [SQ_W-1:0]            sq_ff, sq_in;
   logic [PROD_W-1:0]          pa_ff, pa_in, pb_ff, pb_in;
   logic [Q_W-1:0]             q_ff, q_in;
   logic [NUM_W-1:0]           shift_ff, shift_in, quo_ff, quo_in;
   logic [UNIT_W-1:0]          rem_ff, rem_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [ROOT_W-1:0]          root_ff, root_in;
   logic [ADDR_W-1:0]          idx_ff, idx_in;
   logic                       neg_ff, neg_in;
   logic signed [Z_W-1:0]      z_ff, z_in;
   logic [1:0]                 status_ff, status_in;
   logic                       end_ff, end_in;

   logic                       accept, room;
   csz_wr_type                 wr;
   logic signed [SAMPLE_W-1:0] rd_data;
   logic [UNIT_W-1:0]          unit_a, unit_b, unit_diff;
   logic                       unit_ge;
   logic signed [2*SAMPLE_W-1:0] sample_sq;
   logic signed [PROD_W-1:0]   sum_sq;
   logic signed [DIFF_W-1:0]   nx, dev;
   logic [ZNUM_W-1:0]          qm;

   assign req_ready = (state_ff == ST_LOAD);
   assign accept    = req_valid && req_ready;
   assign room      = (count_ff < CNT_W'(MAX_SAMPLES));
   assign sample_sq = req_sample * req_sample;
   assign sum_sq    = sum_ff * sum_ff;
   assign nx        = DIFF_W'($signed({1'b0, count_ff}) * rd_data);
   assign dev       = nx - DIFF_W'(sum_ff);
   assign qm        = quo_in[ZNUM_W-1:0];

   assign wr.en   = accept && room;
   assign wr.addr = count_ff[ADDR_W-1:0];
   assign wr.data = req_sample;

   csz_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      unit_a = {rem_ff[UNIT_W-2:0], shift_ff[NUM_W-1]};
      unit_b = UNIT_W'(count_ff - CNT_W'(1));
      if (state_ff == ST_ROOT) begin
         unit_a = {rem_ff[UNIT_W-3:0], shift_ff[NUM_W-1:NUM_W-2]};
         unit_b = {quo_ff[UNIT_W-3:0], 2'b01};
      end else if (state_ff == ST_ZDIV) begin
         unit_b = UNIT_W'(root_ff);
      end
   end

   csz_subtract u_subtract (
      .a    (unit_a),
      .b    (unit_b),
      .ge   (unit_ge),
      .diff (unit_diff)
   );

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      sq_in     = sq_ff;
      pa_in     = pa_ff;
      pb_in     = pb_ff;
      q_in      = q_ff;
      shift_in  = shift_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      step_in   = step_ff;
      root_in   = root_ff;
      idx_in    = idx_ff;
      neg_in    = neg_ff;
      z_in      = z_ff;
      status_in = status_ff;
      end_in    = end_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (room) begin
                  count_in = count_ff + CNT_W'(1);
                  sum_in   = sum_ff + SUM_W'(req_sample);
                  sq_in    = sq_ff + SQ_W'(unsigned'(sample_sq));
               end
               if (req_last) begin
                  state_in = ST_PROD;
               end
            end
         end
         ST_PROD: begin
            pa_in = PROD_W'(count_ff * sq_ff);
            pb_in = unsigned'(sum_sq);
            if (count_ff < CNT_W'(2)) begin
               z_in      = '0;
               idx_in    = '0;
               status_in = STATUS_FEW;
               end_in    = 1'b1;
               state_in  = ST_SEND;
            end else begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            q_in     = Q_W'(pa_ff - pb_ff);
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            if (q_ff == '0) begin
               z_in      = '0;
               idx_in    = '0;
               status_in = STATUS_FLAT;
               end_in    = 1'b1;
               state_in  = ST_SEND;
            end else begin
               shift_in = {NQ_W'(count_ff * q_ff), SCALE_SHIFT'(0)};
               quo_in   = '0;
               rem_in   = '0;
               step_in  = STEP_W'(NUM_W);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in   = unit_ge ? unit_diff : unit_a;
            quo_in   = {quo_ff[NUM_W-2:0], unit_ge};
            shift_in = shift_ff << 1;
            step_in  = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               shift_in = {quo_ff[NUM_W-2:0], unit_ge};
               quo_in   = '0;
               rem_in   = '0;
               step_in  = STEP_W'(ROOT_W);
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            rem_in   = unit_ge ? unit_diff : unit_a;
            quo_in   = {quo_ff[NUM_W-2:0], unit_ge};
            shift_in = shift_ff << 2;
            step_in  = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               root_in  = {quo_ff[ROOT_W-2:0], unit_ge};
               idx_in   = '0;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_NORM;
         end
         ST_NORM: begin
            neg_in   = dev[DIFF_W-1];
            shift_in = {MAG_W'(dev[DIFF_W-1] ? -dev : dev), (NUM_W - MAG_W)'(0)};
            quo_in   = '0;
            rem_in   = '0;
            step_in  = STEP_W'(ZNUM_W);
            state_in = ST_ZDIV;
         end
         ST_ZDIV: begin
            rem_in   = unit_ge ? unit_diff : unit_a;
            quo_in   = {quo_ff[NUM_W-2:0], unit_ge};
            shift_in = shift_ff << 1;
            step_in  = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               status_in = STATUS_OK;
               if (neg_ff) begin
                  if (qm > ZNUM_W'(65536)) begin
                     z_in      = -17'sd65536;
                     status_in = STATUS_SAT;
                  end else begin
                     z_in = -$signed(qm[Z_W-1:0]);
                  end
               end else begin
                  if (qm > ZNUM_W'(65535)) begin
                     z_in      = 17'sd65535;
                     status_in = STATUS_SAT;
                  end else begin
                     z_in = $signed(qm[Z_W-1:0]);
                  end
               end
               end_in   = ({1'b0, idx_ff} == count_ff - CNT_W'(1));
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (rsp_ready) begin
               if (end_ff) begin
                  count_in = '0;
                  sum_in   = '0;
                  sq_in    = '0;
                  state_in = ST_LOAD;
               end else begin
                  idx_in   = idx_ff + ADDR_W'(1);
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         sum_ff   <= '0;
         sq_ff    <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         sq_ff    <= sq_in;
      end
      pa_ff     <= pa_in;
      pb_ff     <= pb_in;
      q_ff      <= q_in;
      shift_ff  <= shift_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      step_ff   <= step_in;
      root_ff   <= root_in;
      idx_ff    <= idx_in;
      neg_ff    <= neg_in;
      z_ff      <= z_in;
      status_ff <= status_in;
      end_ff    <= end_in;
   end

   assign rsp_valid      = (state_ff == ST_SEND);
   assign rsp_z_value    = z_ff;
   assign rsp_position   = idx_ff;
   assign rsp_status     = status_ff;
   assign rsp_end_of_run = end_ff;

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("Block took a sample while a result was pending.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SAMPLES))
      else $error("Sample count exceeded the store depth.");

   a_error_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_FEW || rsp_status == STATUS_FLAT))
         |-> (rsp_end_of_run && rsp_position == '0))
      else $error("An error result did not close the block.");

   a_cleared: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_end_of_run) |=> (count_ff == '0 && req_ready))
      else $error("Block was not emptied after its final result.");
endmodule
`default_nettype wire

@@ design/csz_subtract.sv @@
// Shared compare-and-subtract unit used by every division and square-root step.
`default_nettype none
module csz_subtract import csz_pkg::*; (
   input  wire logic [UNIT_W-1:0] a,
   input  wire logic [UNIT_W-1:0] b,
   output logic                   ge,
   output logic [UNIT_W-1:0]      diff
);
   logic borrow;

   assign {borrow, diff} = {1'b0, a} - {1'b0, b};
   assign ge = !borrow;
endmodule
`default_nettype wire

@@ design/csz_store.sv @@
// Sample memory with one write port and a registered read port.
`default_nettype none
module csz_store import csz_pkg::*; (
   input  wire logic                       clock,
   input  wire csz_wr_type                 wr,
   input  wire logic [ADDR_W-1:0]          rd_addr,
   output logic signed [SAMPLE_W-1:0]      rd_data
);
   logic signed [SAMPLE_W-1:0] mem [MAX_SAMPLES];
   logic signed [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire
